[hw/rtl/okt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okt_pkg
// Shared types and constants for the ordered key table.
// ----------------------------------------------------------------------------
package okt_pkg;

    localparam int KEY_W               = 32;
    localparam int VAL_W               = 32;
    localparam int ENTRY_W             = KEY_W + VAL_W;
    localparam int DEFAULT_TABLE_DEPTH = 64;

    // Command codes carried on the slave tuser
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_START = 2'd2
    } t_cmd;

    // Result status carried on the master tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Outcome of the shared key comparator
    typedef struct packed {
        logic lt;   // stored key below search key (signed)
        logic eq;   // stored key equals search key
    } t_cmp_res;

endpackage

[hw/rtl/okt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module okt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/okt_cmp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okt_cmp
// Shared signed key comparator used by every search.
// ----------------------------------------------------------------------------
module okt_cmp (
    input  logic [okt_pkg::KEY_W-1:0] i_stored_key,
    input  logic [okt_pkg::KEY_W-1:0] i_search_key,
    output okt_pkg::t_cmp_res         o_res
);
    import okt_pkg::*;

    assign o_res.lt = $signed(i_stored_key) < $signed(i_search_key);
    assign o_res.eq = i_stored_key == i_search_key;

endmodule

[hw/rtl/ordered_key_table_with_cursor.sv]
`timescale 1ns / 1ps
// Sequence: a linear search reads and compares entries from the first up to the first key not
//   below the target; an insert then shifts entries up from the end, a delete shifts them down,
//   and every item ends by loading the output register (N = stored entries).
// Throughput: one item at a time; the single RAM read port and the comparator set the pace.
// Reset: synchronous active-low clears entry count, cursor, direction and handshake state;
//   the entry RAM is not cleared, only the first N entries are ever used.
// ----------------------------------------------------------------------------
// ordered_key_table_with_cursor
// Key-sorted table of signed key/value pairs with a traversal cursor,
// driven by a small sequencer around one RAM and one shared comparator.
// ----------------------------------------------------------------------------
module ordered_key_table_with_cursor #(
    parameter int TABLE_DEPTH = okt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [31:0] key_in, [63:32] value_in, [64] direction
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    // Master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] read_value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import okt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_INS_RD,
        S_INS_WR,
        S_STEP_RD,
        S_STEP_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_START_RD,
        S_START_WR,
        S_DONE
    } t_state;

    t_state             r_state;

    // Latched item
    t_cmd               r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_val;

    // Table and cursor state
    logic [CNT_W-1:0]   r_count;
    logic [KEY_W-1:0]   r_cur_key;
    logic               r_cur_valid;
    logic               r_walk_desc;

    // Sequencer working registers
    logic [KEY_W-1:0]   r_skey;     // key being searched for
    logic [CNT_W-1:0]   r_idx;      // search position, then hit/insert position
    logic [CNT_W-1:0]   r_j;        // shift pointer
    logic [VAL_W-1:0]   r_res_rv;
    t_status            r_res_st;

    // Output register
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_rv;
    t_status            r_out_st;

    // RAM ports
    logic               w_we;
    logic [CNT_W-1:0]   w_wptr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [CNT_W-1:0]   w_rptr;
    logic [ENTRY_W-1:0] w_rdata;
    logic [KEY_W-1:0]   w_rd_key;
    logic [VAL_W-1:0]   w_rd_val;

    t_cmp_res           w_cmp;
    logic               w_in_range;
    logic               w_more;
    logic               w_hit;
    logic               w_full;

    // Entry store: key in the upper half, value in the lower half
    okt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wptr[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_rptr[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rd_key = w_rdata[ENTRY_W-1:VAL_W];
    assign w_rd_val = w_rdata[VAL_W-1:0];

    okt_cmp u_cmp (
        .i_stored_key (w_rd_key),
        .i_search_key (r_skey),
        .o_res        (w_cmp)
    );

    // Search verdict for the entry just read at r_idx
    assign w_in_range = r_idx < r_count;
    assign w_more     = w_in_range && w_cmp.lt;
    assign w_hit      = w_in_range && w_cmp.eq;
    assign w_full     = r_count == CNT_W'(TABLE_DEPTH);

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_rv;
    assign m_axis_tuser  = r_out_st;

    // RAM address and write steering per sequencer state
    always_comb begin
        w_we    = 1'b0;
        w_wptr  = r_idx;
        w_wdata = {r_key, r_val};
        w_rptr  = r_idx;
        unique case (r_state)
            S_SRCH_CMP: begin
                // replace the value of a present key in place
                if (!w_more && w_hit && r_cmd == CMD_WRITE && r_val != '0) begin
                    w_we = 1'b1;
                end
            end
            S_INS_RD: begin
                w_rptr = r_j - CNT_W'(1);
                if (r_j <= r_idx) begin
                    w_we = 1'b1;
                end
            end
            S_INS_WR: begin
                w_we    = 1'b1;
                w_wptr  = r_j;
                w_wdata = w_rdata;
            end
            S_STEP_RD: begin
                w_rptr = r_walk_desc ? r_idx - CNT_W'(1) : r_idx + CNT_W'(1);
            end
            S_DEL_RD: begin
                w_rptr = r_j + CNT_W'(1);
            end
            S_DEL_WR: begin
                w_we    = 1'b1;
                w_wptr  = r_j;
                w_wdata = w_rdata;
            end
            S_START_RD: begin
                w_rptr = r_walk_desc ? r_count - CNT_W'(1) : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cur_key   <= '0;
            r_cur_valid <= 1'b0;
            r_walk_desc <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the output item once taken; S_DONE reloads it itself
            if (m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd    <= t_cmd'(s_axis_tuser);
                        r_key    <= s_axis_tdata[KEY_W-1:0];
                        r_val    <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
                        r_idx    <= '0;
                        r_res_rv <= '0;
                        unique case (s_axis_tuser)
                            CMD_WRITE: begin
                                r_res_st <= ST_OK;
                                r_skey   <= s_axis_tdata[KEY_W-1:0];
                                r_state  <= S_SRCH_RD;
                            end
                            CMD_READ: begin
                                if (r_count == '0 || !r_cur_valid) begin
                                    r_res_st <= ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_res_st <= ST_OK;
                                    r_skey   <= r_cur_key;
                                    r_state  <= S_SRCH_RD;
                                end
                            end
                            CMD_START: begin
                                r_res_st    <= ST_OK;
                                r_walk_desc <= s_axis_tdata[KEY_W+VAL_W];
                                if (r_count == '0) begin
                                    r_cur_valid <= 1'b0;
                                    r_state     <= S_DONE;
                                end else begin
                                    r_state <= S_START_RD;
                                end
                            end
                            default: begin
                                r_res_st <= ST_OK;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end

                S_SRCH_RD: begin
                    r_state <= S_SRCH_CMP;
                end

                S_SRCH_CMP: begin
                    if (w_more) begin
                        // advance the linear scan one entry
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_SRCH_RD;
                    end else begin
                        // an insert shifts down from the end, everything else works from the hit
                        r_j <= (r_cmd == CMD_WRITE && r_val != '0) ? r_count : r_idx;
                        if (r_cmd == CMD_READ) begin
                            if (w_hit) begin
                                r_res_rv <= w_rd_val;
                                r_state  <= S_STEP_RD;
                            end else begin
                                r_cur_valid <= 1'b0;
                                r_res_st    <= ST_EMPTY;
                                r_state     <= S_DONE;
                            end
                        end else if (r_val != '0) begin
                            if (w_hit) begin
                                r_state <= S_DONE;
                            end else if (w_full) begin
                                r_res_st <= ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_INS_RD;
                            end
                        end else if (w_hit) begin
                            // deleting the cursor's entry moves the cursor on first
                            if (r_cur_valid && r_cur_key == r_key) begin
                                r_state <= S_STEP_RD;
                            end else begin
                                r_state <= S_DEL_RD;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end

                S_INS_RD: begin
                    if (r_j > r_idx) begin
                        r_state <= S_INS_WR;
                    end else begin
                        if (r_count == '0) begin
                            r_cur_key   <= r_key;
                            r_cur_valid <= 1'b1;
                        end
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_DONE;
                    end
                end

                S_INS_WR: begin
                    r_j     <= r_j - CNT_W'(1);
                    r_state <= S_INS_RD;
                end

                S_STEP_RD: begin
                    if (r_walk_desc ? (r_idx != '0) : (r_idx + CNT_W'(1) < r_count)) begin
                        r_state <= S_STEP_WR;
                    end else begin
                        r_cur_valid <= 1'b0;
                        r_state     <= (r_cmd == CMD_READ) ? S_DONE : S_DEL_RD;
                    end
                end

                S_STEP_WR: begin
                    r_cur_key   <= w_rd_key;
                    r_cur_valid <= 1'b1;
                    r_state     <= (r_cmd == CMD_READ) ? S_DONE : S_DEL_RD;
                end

                S_DEL_RD: begin
                    if (r_j + CNT_W'(1) < r_count) begin
                        r_state <= S_DEL_WR;
                    end else begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_DONE;
                    end
                end

                S_DEL_WR: begin
                    r_j     <= r_j + CNT_W'(1);
                    r_state <= S_DEL_RD;
                end

                S_START_RD: begin
                    r_state <= S_START_WR;
                end

                S_START_WR: begin
                    r_cur_key   <= w_rd_key;
                    r_cur_valid <= 1'b1;
                    r_state     <= S_DONE;
                end

                S_DONE: begin
                    // hold the result until the output register is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_rv    <= r_res_rv;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_empty_no_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !r_cur_valid)
        else $error("cursor valid on an empty table");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_st == ST_FULL) |-> w_full)
        else $error("full status with free entries");

    a_ram_write_on_write_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_cmd == CMD_WRITE))
        else $error("table written by a non-write command");

    a_count_change_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_count != $past(r_count) && $past(r_state) != S_IDLE)
            |-> (r_state == S_DONE))
        else $error("entry count changed mid-sequence");
`endif

endmodule

[verif/tb_ordered_key_table_with_cursor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_key_table_with_cursor
// Self-checking bench for the ordered key table: a directed script covering
// the corner behaviour of inserts, deletes, reads and traversal starts, a fill
// up to the full table, then three randomised phases under varying stream
// back-pressure, every reply checked against an in-bench table predictor.
// ----------------------------------------------------------------------------
module tb_ordered_key_table_with_cursor;

    import okt_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int KEY_POOL_SIZE = 96;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off in the last phase
    localparam int TAIL_CYCLES   = 300;   // worst insert/delete pass on a full table
    localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake before giving up

    // The command field has a fourth code that the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] key;
        logic signed [31:0] val;
        logic               dir;
    } t_request;

    typedef struct packed {
        logic signed [31:0] value;
        t_status            status;
    } t_reply;

    typedef struct packed {
        t_request req;
        logic     typed;   // use the reply below rather than the predictor
        t_reply   want;
    } t_script_row;

    localparam t_reply R_OK    = '{32'sd0, ST_OK};
    localparam t_reply R_EMPTY = '{32'sd0, ST_EMPTY};
    localparam t_reply R_FULL  = '{32'sd0, ST_FULL};
    localparam logic   TYPED   = 1'b1;
    localparam logic   PREDICT = 1'b0;

    localparam int SCRIPT_ROWS = 23;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // [31:0] key_in, [63:32] value_in, [64] direction
    logic [1:0]  s_axis_tuser;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] read_value
    logic [1:0]  m_axis_tuser;   // [1:0] status

    ordered_key_table_with_cursor #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Table predictor: a sorted copy of the table plus the traversal cursor
    // ------------------------------------------------------------------------
    logic signed [31:0] shadow_key [TABLE_DEPTH];
    logic signed [31:0] shadow_val [TABLE_DEPTH];
    int                 shadow_count;
    logic signed [31:0] cursor_at;
    logic               cursor_live;
    logic               walk_down;

    // Replies still owed by the block, oldest first
    t_reply expected_replies [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off_req;
    int  mismatches;
    int  requests_sent;
    int  replies_seen;
    int  full_rejects;
    int  failed_reads;
    int  peak_fill;
    logic signed [31:0] key_pool [KEY_POOL_SIZE];

    // Position of the first stored key not below k (shadow_count if none)
    function automatic int slot_for(logic signed [31:0] k);
        int i;
        i = 0;
        while (i < shadow_count && shadow_key[i] < k) i++;
        return i;
    endfunction

    function automatic bit holds_key(int i, logic signed [31:0] k);
        return i < shadow_count && shadow_key[i] == k;
    endfunction

    // Advance the cursor one entry from slot i in the stored direction
    function automatic void cursor_step(int i);
        if (walk_down) begin
            cursor_live = (i > 0);
            if (i > 0) cursor_at = shadow_key[i - 1];
        end else begin
            cursor_live = (i + 1 < shadow_count);
            if (i + 1 < shadow_count) cursor_at = shadow_key[i + 1];
        end
    endfunction

    // Apply one command to the shadow table and return the reply it causes
    function automatic t_reply table_apply(t_request req);
        t_reply r;
        int     i;
        r = R_OK;
        case (req.cmd)
            CMD_WRITE: begin
                i = slot_for(req.key);
                if (req.val != 0) begin
                    if (holds_key(i, req.key)) begin
                        shadow_val[i] = req.val;
                    end else if (shadow_count >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int j = shadow_count; j > i; j--) begin
                            shadow_key[j] = shadow_key[j - 1];
                            shadow_val[j] = shadow_val[j - 1];
                        end
                        shadow_key[i] = req.key;
                        shadow_val[i] = req.val;
                        // first entry of an empty table takes the cursor
                        if (shadow_count == 0) begin
                            cursor_at   = req.key;
                            cursor_live = 1'b1;
                        end
                        shadow_count++;
                    end
                end else if (holds_key(i, req.key)) begin
                    // move the cursor off an entry that is about to vanish
                    if (cursor_live && cursor_at == req.key) cursor_step(i);
                    for (int j = i; j + 1 < shadow_count; j++) begin
                        shadow_key[j] = shadow_key[j + 1];
                        shadow_val[j] = shadow_val[j + 1];
                    end
                    shadow_count--;
                end
            end
            CMD_READ: begin
                if (shadow_count == 0 || !cursor_live) begin
                    r.status = ST_EMPTY;
                end else begin
                    i = slot_for(cursor_at);
                    if (holds_key(i, cursor_at)) begin
                        r.value = shadow_val[i];
                        cursor_step(i);
                    end else begin
                        cursor_live = 1'b0;
                        r.status    = ST_EMPTY;
                    end
                end
            end
            CMD_START: begin
                walk_down = req.dir;
                if (shadow_count == 0) begin
                    cursor_live = 1'b0;
                end else begin
                    cursor_at   = req.dir ? shadow_key[shadow_count - 1] : shadow_key[0];
                    cursor_live = 1'b1;
                end
            end
            default: ;   // unused code: no effect
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Slave side: offer one item, hold it until taken, then predict its reply
    // ------------------------------------------------------------------------
    task automatic send_request(input t_request req, input logic typed, input t_reply want);
        t_reply predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, req.dir, req.val, req.key};
        s_axis_tuser  <= req.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = table_apply(req);
        expected_replies.push_back(typed ? want : predicted);
        requests_sent++;
        if (predicted.status == ST_FULL) full_rejects++;
        if (predicted.status == ST_EMPTY) failed_reads++;
        if (shadow_count > peak_fill) peak_fill = shadow_count;
    endtask

    // Drop valid and wait for every outstanding reply
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    // Random command; writes mostly hit a small key pool so that replaces
    // and deletes of present keys are common
    function automatic t_request random_request(int delete_pct);
        t_request req;
        int       pick;
        req.key = $urandom;
        req.val = $urandom;
        req.dir = 1'($urandom_range(1));
        pick    = $urandom_range(99);
        if (pick < 2)        req.cmd = CMD_UNUSED;
        else if (pick < 10)  req.cmd = CMD_START;
        else if (pick < 42)  req.cmd = CMD_READ;
        else begin
            req.cmd = CMD_WRITE;
            if ($urandom_range(9) < 8) req.key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
            if ($urandom_range(99) < delete_pct) req.val = 32'sd0;
            else if (req.val == 0) req.val = 32'sd1;
        end
        return req;
    endfunction

    task automatic random_phase(input int count, input int delete_pct);
        repeat (count) send_request(random_request(delete_pct), PREDICT, R_OK);
    endtask

    // ------------------------------------------------------------------------
    // Directed script: empty-table behaviour, extremes of key and value,
    // first insert, replace, delete of an absent key and of the cursor entry
    // in both directions, walking off the end, unused command
    // ------------------------------------------------------------------------
    t_script_row script [SCRIPT_ROWS] = '{
        '{'{CMD_READ,   32'sd0,  32'sd0,          1'b0}, TYPED,   R_EMPTY},
        '{'{CMD_START,  32'sd0,  32'sd0,          1'b1}, TYPED,   R_OK},
        '{'{CMD_UNUSED, KEY_MAX, 32'shFFFF_FFFF,  1'b1}, TYPED,   R_OK},
        '{'{CMD_WRITE,  32'sd5,  32'sd0,          1'b0}, TYPED,   R_OK},
        '{'{CMD_WRITE,  KEY_MIN, 32'sh7FFF_FFFF,  1'b0}, TYPED,   R_OK},
        '{'{CMD_WRITE,  KEY_MAX, 32'sh8000_0000,  1'b0}, TYPED,   R_OK},
        '{'{CMD_WRITE,  32'sd0,  32'shFFFF_FFFF,  1'b0}, TYPED,   R_OK},
        '{'{CMD_READ,   32'sd0,  32'sd0,          1'b0}, PREDICT, R_OK},
        '{'{CMD_READ,   32'sd0,  32'sd0,          1'b0}, PREDICT, R_OK},
        '{'{CMD_START,  32'sd0,  32'sd0,          1'b0}, TYPED,   R_OK},
        '{'{CMD_READ,   32'sd0,  32'sd0,          1'b0}, PREDICT, R_OK},
        '{'{CMD_WRITE,  32'sd0,  32'sd1234,       1'b0}, TYPED,   R_OK},
        '{'{CMD_READ,   32'sd0,  32'sd0,          1'b0}, PREDICT, R_OK},
        '{'{CMD_WRITE,  KEY_MAX, 32'sd0,          1'b0}, TYPED,   R_OK},
        '{'{CMD_READ,   32'sd0,  32'sd0,          1'b0}, PREDICT, R_OK},
        '{'{CMD_START,  32'sd0,  32'sd0,          1'b1}, TYPED,   R_OK},
        '{'{CMD_WRITE,  32'sd0,  32'sd0,          1'b0}, TYPED,   R_OK},
        '{'{CMD_READ,   32'sd0,  32'sd0,          1'b0}, PREDICT, R_OK},
        '{'{CMD_WRITE,  KEY_MIN, 32'sd0,          1'b0}, TYPED,   R_OK},
        '{'{CMD_READ,   32'sd0,  32'sd0,          1'b0}, TYPED,   R_EMPTY},
        '{'{CMD_START,  32'sd0,  32'sd0,          1'b0}, TYPED,   R_OK},
        '{'{CMD_WRITE,  -32'sd1, 32'shAAAA_AAAA,  1'b0}, TYPED,   R_OK},
        '{'{CMD_READ,   32'sd0,  32'sd0,          1'b0}, PREDICT, R_OK}
    };

    // ------------------------------------------------------------------------
    // Master side: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : reply_ready
        int stall_left;
        stall_left    = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare every reply taken against the oldest expectation
    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
                $error("unexpected reply: read_value %0d, status %0d",
                       $signed(m_axis_tdata), m_axis_tuser);
                mismatches++;
            end else begin
                want = expected_replies.pop_front();
                if (m_axis_tdata !== want.value) begin
                    $error("read_value: expected %0d, got %0d",
                           want.value, $signed(m_axis_tdata));
                    mismatches++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    // Give up once neither side has moved an item for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_request req;
        int       slot;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_rst_n       <= 1'b0;
        hold_off_req  = 1'b0;
        mismatches    = 0;
        requests_sent = 0;
        replies_seen  = 0;
        full_rejects  = 0;
        failed_reads  = 0;
        peak_fill     = 0;
        shadow_count  = 0;
        cursor_at     = '0;
        cursor_live   = 1'b0;
        walk_down     = 1'b0;

        // Pool of recurring keys, seeded with the signed extremes and zero
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        key_pool[4] = 32'sd1;
        for (int k = 5; k < KEY_POOL_SIZE; k++) key_pool[k] = $urandom;

        // Phase one: sender mostly busy, receiver often stalls
        send_idle_pct = 7;
        recv_idle_pct = 52;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < SCRIPT_ROWS; r++)
            send_request(script[r].req, script[r].typed, script[r].want);

        // Fill the table to the brim with random keys
        while (shadow_count < TABLE_DEPTH) begin
            req = '{CMD_WRITE, $urandom, $urandom | 32'sd1, 1'b0};
            send_request(req, PREDICT, R_OK);
        end

        // A new key on a full table is dropped...
        req = '{CMD_WRITE, $urandom, $urandom | 32'sd1, 1'b0};
        while (holds_key(slot_for(req.key), req.key)) req.key = $urandom;
        send_request(req, TYPED, R_FULL);

        // ...while replacing a present key still succeeds
        slot = $urandom_range(TABLE_DEPTH - 1);
        req  = '{CMD_WRITE, shadow_key[slot], 32'sh1357_9BDF, 1'b0};
        send_request(req, TYPED, R_OK);

        // Insert-heavy traffic keeps the table near full
        random_phase(200, 15);
        drain_replies();

        // Phase two: sender often idle, receiver mostly ready; delete-heavy
        send_idle_pct = 52;
        recv_idle_pct = 7;
        random_phase(220, 70);
        drain_replies();

        // Phase three: no idling; hold the receiver off so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req  = 1'b1;
        random_phase(220, 35);
        drain_replies();

        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_replies.size() != 0) begin
            $error("%0d replies never arrived", expected_replies.size());
            mismatches += expected_replies.size();
        end

        $display("Sent %0d commands, checked %0d replies; table peaked at %0d entries.",
                 requests_sent, replies_seen, peak_fill);
        $display("Saw %0d writes rejected on a full table and %0d failed reads.",
                 full_rejects, failed_reads);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
